// ===== design/dtpc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the digit trie prefix-conflict checker.
// Holds the request and response types, command codes, control state and step flags.
// No dependencies.
package dtpc_pkg;

    localparam int DIGIT_W = 4;

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_DIGIT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } req_t;

    typedef struct packed {
        logic number_conflict;
        logic list_consistent;
        logic pool_overflow;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WORK
    } state_t;

    typedef struct packed {
        logic hit;
        logic ovf;
        logic alloc;
    } step_t;

endpackage

// ===== design/digit_trie_prefix_conflict.sv =====
`timescale 1ns / 1ps
// Top level of the digit trie prefix-conflict checker: node pool memory and control.
// Depends on dtpc_pkg and dtpc_step.

// For a digit request, the trie row of the current node is read from the node pool
// memory into a register, and the updated row is written back in the work state, which
// waits on a last digit while an earlier response is held. Each pool row holds, for
// every digit, the child index and the end and pass-through marks of that child. A
// clear request sweeps one row per cycle over the nodes in use (the value of the free
// pointer, at least one row), and after reset the sweep covers all NODES rows; no
// request is taken during a sweep. A response appears on the last digit of each number
// and is held in an output register, so the next request can be taken while it waits.
module digit_trie_prefix_conflict #(
    parameter int NODES = 4096,
    parameter int RADIX = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  dtpc_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output dtpc_pkg::rsp_t  rsp_data
);
    import dtpc_pkg::*;

    localparam int IDXW = $clog2(NODES);
    localparam int DW   = (RADIX > 2) ? $clog2(RADIX) : 1;
    localparam int SW   = IDXW + 2;
    localparam int ROWW = RADIX * SW;

    logic [ROWW-1:0] pool_mem [NODES];
    logic [ROWW-1:0] rd_data_reg;
    logic            rd_en;
    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    logic [ROWW-1:0] wr_data;

    state_t          state_reg, state_next;
    logic [IDXW-1:0] clr_addr_reg, clr_addr_next;
    logic [IDXW-1:0] clr_last_reg, clr_last_next;
    logic [IDXW-1:0] cur_node_reg, cur_node_next;
    logic [IDXW:0]   next_free_reg, next_free_next;
    logic            conflict_reg, conflict_next;
    logic            overflow_reg, overflow_next;
    logic            hit_reg, hit_next;
    logic            skip_reg, skip_next;
    req_t            req_reg, req_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_reg, out_next;

    logic [DW-1:0]   dig;
    logic [ROWW-1:0] row_next;
    logic [IDXW-1:0] child;
    step_t           step;
    logic            active;
    logic            hit_now;
    logic            ovf_now;

    always_comb
    begin
        if (32'(req_reg.digit) >= RADIX)
        begin
            dig = DW'(RADIX - 1);
        end
        else
        begin
            dig = DW'(req_reg.digit);
        end
    end

    dtpc_step #(
        .NODES (NODES),
        .RADIX (RADIX)
    ) u_step (
        .row       (rd_data_reg),
        .dig       (dig),
        .last      (req_reg.last_digit),
        .next_free (next_free_reg),
        .row_next  (row_next),
        .child     (child),
        .step      (step)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pool_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= pool_mem[cur_node_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_last_reg  <= IDXW'(NODES - 1);
            cur_node_reg  <= '0;
            next_free_reg <= (IDXW+1)'(1);
            conflict_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_last_reg  <= clr_last_next;
            cur_node_reg  <= cur_node_next;
            next_free_reg <= next_free_next;
            conflict_reg  <= conflict_next;
            overflow_reg  <= overflow_next;
            hit_reg       <= hit_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_last_next  = clr_last_reg;
        cur_node_next  = cur_node_reg;
        next_free_next = next_free_reg;
        conflict_next  = conflict_reg;
        overflow_next  = overflow_reg;
        hit_next       = hit_reg;
        skip_next      = skip_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cur_node_reg;
        wr_data        = row_next;
        req_ready      = (state_reg == ST_IDLE);
        active         = !conflict_reg && !skip_reg;
        hit_now        = active && step.hit;
        ovf_now        = active && step.ovf;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (clr_addr_reg == clr_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    if (req_data.cmd == CMD_CLEAR)
                    begin
                        state_next     = ST_CLEAR;
                        clr_addr_next  = '0;
                        clr_last_next  = IDXW'(next_free_reg - 1'b1);
                        cur_node_next  = '0;
                        next_free_next = (IDXW+1)'(1);
                        conflict_next  = 1'b0;
                        overflow_next  = 1'b0;
                        hit_next       = 1'b0;
                        skip_next      = 1'b0;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_WORK;
                    end
                end
            end
            ST_WORK:
            begin
                if (!(req_reg.last_digit && out_valid_reg && !rsp_ready))
                begin
                    state_next = ST_IDLE;
                    if (active)
                    begin
                        priority if (step.hit)
                        begin
                            hit_next      = 1'b1;
                            conflict_next = 1'b1;
                            skip_next     = 1'b1;
                        end
                        else if (step.ovf)
                        begin
                            overflow_next = 1'b1;
                            skip_next     = 1'b1;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (step.alloc)
                            begin
                                next_free_next = next_free_reg + 1'b1;
                            end
                            if (!req_reg.last_digit)
                            begin
                                cur_node_next = child;
                            end
                        end
                    end
                    if (req_reg.last_digit)
                    begin
                        out_valid_next           = 1'b1;
                        out_next.number_conflict = hit_reg | hit_now;
                        out_next.list_consistent = !(conflict_reg | hit_now);
                        out_next.pool_overflow   = overflow_reg | ovf_now;
                        cur_node_next            = '0;
                        hit_next                 = 1'b0;
                        skip_next                = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// ===== design/dtpc_step.sv =====
`timescale 1ns / 1ps
// Row update for one digit: selects the digit slot of a trie row, checks marks, allocates.
// Depends on dtpc_pkg.
module dtpc_step #(
    parameter int NODES = 4096,
    parameter int RADIX = 10
) (
    row,
    dig,
    last,
    next_free,
    row_next,
    child,
    step
);
    import dtpc_pkg::*;

    localparam int IDXW = $clog2(NODES);
    localparam int DW   = (RADIX > 2) ? $clog2(RADIX) : 1;
    localparam int SW   = IDXW + 2;
    localparam int ROWW = RADIX * SW;

    input  logic [ROWW-1:0]  row;
    input  logic [DW-1:0]    dig;
    input  logic             last;
    input  logic [IDXW:0]    next_free;
    output logic [ROWW-1:0]  row_next;
    output logic [IDXW-1:0]  child;
    output dtpc_pkg::step_t  step;

    logic [SW-1:0]   slot;
    logic [SW-1:0]   slot_next;
    logic [IDXW-1:0] old_child;
    logic            end_mark;
    logic            pass_mark;
    logic            pool_full;

    always_comb
    begin
        slot      = row[dig*SW +: SW];
        old_child = slot[IDXW-1:0];
        end_mark  = slot[IDXW];
        pass_mark = slot[IDXW+1];
        pool_full = (next_free >= (IDXW+1)'(NODES));

        step.hit   = (old_child != '0) && (end_mark || (last && pass_mark));
        step.alloc = !step.hit && (old_child == '0) && !pool_full;
        step.ovf   = !step.hit && (old_child == '0) && pool_full;

        child = step.alloc ? next_free[IDXW-1:0] : old_child;

        slot_next = {pass_mark | !last, end_mark | last, child};

        row_next = row;
        row_next[dig*SW +: SW] = slot_next;
    end

endmodule

// ===== design/dtpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the digit trie prefix-conflict checker, with its bind statement.
// Depends on dtpc_pkg and digit_trie_prefix_conflict.
module dtpc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input dtpc_pkg::req_t  req_data,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input dtpc_pkg::rsp_t  rsp_data
);
    import dtpc_pkg::*;

    // A stalled response keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

    // Every request keeps the block busy, so requests are never taken back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken in back-to-back cycles");

    // A conflicting number always marks the list as inconsistent.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.number_conflict |-> !rsp_data.list_consistent)
    else $error("conflict reported on a consistent list");

    // A new response never appears in the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_valid && req_ready))
    else $error("response appeared without the write-back cycle");

endmodule

bind digit_trie_prefix_conflict dtpc_checker u_dtpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

// ===== bench/dtpc_trie_watch.sv =====
`timescale 1ns / 1ps
// Watcher for the digit trie prefix-conflict checker: keeps its own trie, predicts
// every response from the accepted requests and compares the responses that come back.
// Depends on dtpc_pkg.
module dtpc_trie_watch #(
    parameter int NODES = 4096,
    parameter int RADIX = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  dtpc_pkg::req_t req_data,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  dtpc_pkg::rsp_t rsp_data,
    output int             pending,
    output int             mismatches
);
    import dtpc_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int END_BIT = 0;
    localparam int PASS_BIT = 1;

    logic [IDX_W-1:0] child_of [NODES*RADIX];
    logic [1:0]       marks [NODES];
    logic [IDX_W-1:0] cur_node;
    int               free_ptr;
    bit               clash_seen;
    bit               pool_full;
    bit               num_clashed;
    bit               num_dropped;
    rsp_t             verdicts_due[$];
    int               fails;
    int               seen;

    assign mismatches = fails;

    function automatic void wipe_trie();
        for (int i = 0; i < NODES * RADIX; i++)
        begin
            child_of[i] = '0;
        end
        for (int i = 0; i < NODES; i++)
        begin
            marks[i] = '0;
        end
        cur_node = '0;
        free_ptr = 1;
        clash_seen = 1'b0;
        pool_full = 1'b0;
        num_clashed = 1'b0;
        num_dropped = 1'b0;
    endfunction

    function automatic bit take_digit(input req_t r, output rsp_t verdict);
        int               d;
        int               slot;
        logic [IDX_W-1:0] kid;
        verdict = '0;
        if (r.cmd == CMD_CLEAR)
        begin
            wipe_trie();
            return 1'b0;
        end
        d = int'(r.digit);
        if (d >= RADIX)
            d = RADIX - 1;
        if (!clash_seen && !num_dropped)
        begin
            slot = int'(cur_node) * RADIX + d;
            kid = child_of[slot];
            if (kid != 0 && (marks[kid][END_BIT] || (r.last_digit && marks[kid][PASS_BIT])))
            begin
                num_clashed = 1'b1;
                clash_seen = 1'b1;
                num_dropped = 1'b1;
            end
            else
            begin
                if (kid == 0)
                begin
                    if (free_ptr < NODES)
                    begin
                        kid = IDX_W'(free_ptr);
                        free_ptr++;
                        child_of[slot] = kid;
                    end
                    else
                    begin
                        pool_full = 1'b1;
                        num_dropped = 1'b1;
                    end
                end
                if (!num_dropped)
                begin
                    if (r.last_digit)
                        marks[kid][END_BIT] = 1'b1;
                    else
                    begin
                        marks[kid][PASS_BIT] = 1'b1;
                        cur_node = kid;
                    end
                end
            end
        end
        if (!r.last_digit)
            return 1'b0;
        verdict.number_conflict = num_clashed;
        verdict.list_consistent = !clash_seen;
        verdict.pool_overflow = pool_full;
        cur_node = '0;
        num_clashed = 1'b0;
        num_dropped = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t due;
        rsp_t verdict;
        if (!rst_n)
        begin
            wipe_trie();
            verdicts_due.delete();
            fails = 0;
            seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                seen <= seen + 1;
                if (verdicts_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: response %0d arrived with none expected: %0b %0b %0b",
                                 $realtime, seen, rsp_data.number_conflict,
                                 rsp_data.list_consistent, rsp_data.pool_overflow);
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    if (rsp_data.number_conflict !== due.number_conflict
                        || rsp_data.list_consistent !== due.list_consistent
                        || rsp_data.pool_overflow !== due.pool_overflow)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: response %0d expected %0b%0b%0b, got %0b%0b%0b",
                                     $realtime, seen, due.number_conflict,
                                     due.list_consistent, due.pool_overflow,
                                     rsp_data.number_conflict, rsp_data.list_consistent,
                                     rsp_data.pool_overflow);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (take_digit(req_data, verdict))
                    verdicts_due.push_back(verdict);
            end
            pending <= verdicts_due.size();
        end
    end

endmodule

// ===== bench/digit_trie_prefix_conflict_test.sv =====
`timescale 1ns / 1ps
// Top of the digit trie prefix-conflict testbench: clock, reset, request and response
// traffic, watchdog and verdict. Depends on dtpc_pkg, dtpc_trie_watch and the block.
module digit_trie_prefix_conflict_test;

    import dtpc_pkg::*;

    localparam int NODES = 128;
    localparam int RADIX = 10;
    localparam int ITEMS = 1900;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_LEN = 8;

    typedef struct packed {
        logic [3:0]         len;
        logic [7:0][3:0]    dig;
    } number_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_data;
    int   pending;
    int   mismatches;
    int   n_sent;
    bit   idle_on;
    int   holds_asked;
    int   holds_done;
    int   stall_cycles;

    digit_trie_prefix_conflict #(
        .NODES(NODES),
        .RADIX(RADIX)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

    dtpc_trie_watch #(
        .NODES(NODES),
        .RADIX(RADIX)
    ) i_watch (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data),
        .pending(pending),
        .mismatches(mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [3:0] pick_digit();
        if ($urandom_range(0, 99) < 12)
            return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
    endfunction

    function automatic number_t make_num(input int len, input logic [31:0] digits);
        number_t n;
        n = '0;
        n.len = 4'(len);
        for (int i = 0; i < len; i++)
        begin
            n.dig[i] = digits[4*(len-1-i) +: 4];
        end
        return n;
    endfunction

    function automatic number_t random_number(input int len);
        number_t n;
        n = '0;
        n.len = 4'(len);
        for (int i = 0; i < len; i++)
        begin
            n.dig[i] = pick_digit();
        end
        return n;
    endfunction

    function automatic number_t relate_to(input number_t p);
        number_t n;
        int      extra;
        n = p;
        case ($urandom_range(0, 2))
            1:
            begin
                if (p.len > 1)
                    n.len = 4'($urandom_range(1, p.len - 1));
            end
            2:
            begin
                if (p.len < MAX_LEN)
                begin
                    extra = $urandom_range(1, MAX_LEN - p.len);
                    for (int i = p.len; i < p.len + extra; i++)
                    begin
                        n.dig[i] = pick_digit();
                    end
                    n.len = 4'(p.len + extra);
                end
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    task automatic send_req(input logic c, input logic [3:0] d, input logic last);
        req_t r;
        r.cmd = c;
        r.digit = d;
        r.last_digit = last;
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 27)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic send_clear();
        send_req(CMD_CLEAR, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_number(input number_t n, input int upto);
        for (int i = 0; i < upto; i++)
        begin
            send_req(CMD_DIGIT, n.dig[i], i == n.len - 1);
        end
    endtask

    task automatic quiesce();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic feed_list();
        number_t dialed[$];
        number_t n;
        int      count;
        int      fixed_len;
        bit      ragged;
        if ($urandom_range(0, 99) < 92)
            send_clear();
        ragged = $urandom_range(0, 99) < 25;
        fixed_len = $urandom_range(1, 7);
        count = $urandom_range(1, 40);
        for (int k = 0; k < count; k++)
        begin
            if (dialed.size() > 0 && $urandom_range(0, 99) < 15)
                n = relate_to(dialed[$urandom_range(0, dialed.size() - 1)]);
            else if (ragged)
                n = random_number($urandom_range(1, MAX_LEN));
            else
                n = random_number(fixed_len);
            if (n.len > 1 && $urandom_range(0, 99) < 4)
            begin
                send_number(n, n.len - 1);
                send_clear();
                dialed.delete();
            end
            else
            begin
                send_number(n, n.len);
                dialed.push_back(n);
            end
        end
    endtask

    initial
    begin
        int lists;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        n_sent = 0;
        idle_on = 1'b1;
        holds_asked = 0;
        lists = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_req(CMD_CLEAR, 4'hf, 1'b1);
        send_number(make_num(1, 32'h0), 1);
        send_number(make_num(2, 32'h12), 2);
        send_number(make_num(3, 32'h345), 3);
        send_number(make_num(1, 32'h1), 1);
        send_number(make_num(2, 32'h77), 2);
        send_req(CMD_CLEAR, 4'h0, 1'b0);
        send_number(make_num(1, 32'hf), 1);
        send_number(make_num(1, 32'hc), 1);
        send_clear();
        send_number(make_num(2, 32'h34), 2);
        send_number(make_num(3, 32'h345), 3);
        send_clear();
        send_req(CMD_DIGIT, 4'h4, 1'b0);
        send_clear();
        send_number(make_num(1, 32'h4), 1);

        while (n_sent < ITEMS)
        begin
            idle_on = !(n_sent >= 900 && n_sent < 1200);
            if ((holds_asked == 0 && n_sent >= 300) || (holds_asked == 1 && n_sent >= 1500))
                holds_asked++;
            if (lists % 20 == 19)
                quiesce();
            feed_list();
            lists++;
        end

        quiesce();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("digit_trie_prefix_conflict: match");
        else
            $display("digit_trie_prefix_conflict: mismatch");
        $finish;
    end

    initial
    begin
        holds_done = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ready <= !(idle_on && $urandom_range(0, 99) < 27);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("digit_trie_prefix_conflict: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

// ===== filelist.f =====
design/dtpc_pkg.sv
design/dtpc_step.sv
design/digit_trie_prefix_conflict.sv
design/dtpc_checker.sv
bench/dtpc_trie_watch.sv
bench/digit_trie_prefix_conflict_test.sv
